/* hdl/esa_pkg.sv */
// Shared types and constants for the exchange sort block.
package esa_pkg;

  // Set capacity and derived widths
  localparam int CAPACITY = 8;
  localparam int AW       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW       = $clog2(CAPACITY + 1);
  localparam int DW       = 16;

  // Input transaction
  typedef struct packed {
    logic signed [DW-1:0] value;
    logic                 final_item;
  } in_item_t;

  // Result transaction
  typedef struct packed {
    logic signed [DW-1:0] sorted_value;
    logic                 end_of_run;
  } out_item_t;

  // Element store access, one write and one read port
  typedef struct packed {
    logic                 we;
    logic [AW-1:0]        waddr;
    logic signed [DW-1:0] wdata;
    logic [AW-1:0]        raddr;
  } mem_req_t;

  // Emit control from the sequencer to the output register
  typedef struct packed {
    logic load;
    logic last;
  } emit_t;

  // Sequencer states, one-hot
  typedef enum logic [6:0] {
    S_LOAD = 7'b0000001,
    S_RDA  = 7'b0000010,
    S_RDB  = 7'b0000100,
    S_CMP  = 7'b0001000,
    S_WRA  = 7'b0010000,
    S_ERD  = 7'b0100000,
    S_EMT  = 7'b1000000
  } state_t;

endpackage

/* hdl/exchange_sort_small_array.sv */
// Load: an item is taken whenever in_valid is high in the load state. Sort: one pass per
// position but the last, each comparing the held element with every later one, paced by
// the single compare/swap unit and one store read per cycle. Emit: a first store read, then
// one result per cycle while the output register is free. One set at a time: input stalls.
// Reset (rst_n low, synchronous): sequencer returns to loading, count cleared, output empty.
// Store contents are not cleared; only entries written in the current set are read.
module exchange_sort_small_array (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  esa_pkg::in_item_t  in_data,
  output logic               in_stall,
  output logic               out_valid,
  input  logic               out_stall,
  output esa_pkg::out_item_t out_data
);

  esa_pkg::mem_req_t             req;
  esa_pkg::emit_t                emit;
  logic signed [esa_pkg::DW-1:0] rdata;
  logic                          out_free;
  logic                          out_valid_r;
  esa_pkg::out_item_t            out_data_r;

  // Output register is free when empty or being taken this cycle
  assign out_free = !out_valid_r || !out_stall;

  esa_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_data  (in_data),
    .in_stall (in_stall),
    .out_free (out_free),
    .rdata    (rdata),
    .req      (req),
    .emit     (emit)
  );

  esa_store u_store (
    .clk   (clk),
    .req   (req),
    .rdata (rdata)
  );

  // Output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit.load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  // Output payload; store read data is valid whenever the load strobe is high
  always_ff @(posedge clk) begin
    if (emit.load) begin
      out_data_r.sorted_value <= rdata;
      out_data_r.end_of_run   <= emit.last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

/* hdl/esa_store.sv */
// Element store: single write port, single registered read port.
module esa_store (
  input  logic                          clk,
  input  esa_pkg::mem_req_t             req,
  output logic signed [esa_pkg::DW-1:0] rdata
);

  logic signed [esa_pkg::DW-1:0] mem [esa_pkg::CAPACITY];
  logic signed [esa_pkg::DW-1:0] rdata_r;

  // Write and registered read
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rdata_r <= mem[req.raddr];
  end

  assign rdata = rdata_r;

endmodule

/* hdl/esa_seq.sv */
// Sequencer and shared compare/swap unit for load, sort and emit.
module esa_seq (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  esa_pkg::in_item_t             in_data,
  output logic                          in_stall,
  input  logic                          out_free,
  input  logic signed [esa_pkg::DW-1:0] rdata,
  output esa_pkg::mem_req_t             req,
  output esa_pkg::emit_t                emit
);

  esa_pkg::state_t               state_r, state_nxt;
  logic [esa_pkg::CW-1:0]        cnt_r, cnt_nxt;
  logic [esa_pkg::CW-1:0]        n_r, n_nxt;
  logic [esa_pkg::AW-1:0]        a_r, a_nxt;
  logic [esa_pkg::AW-1:0]        b_r, b_nxt;
  logic [esa_pkg::AW-1:0]        k_r, k_nxt;
  logic signed [esa_pkg::DW-1:0] cur_r, cur_nxt;

  logic                   in_acc;
  logic [esa_pkg::CW-1:0] cnt_inc;
  logic                   set_end;
  logic                   swap;
  logic                   b_last;
  logic                   a_last;
  logic                   k_last;

  assign in_stall = (state_r != esa_pkg::S_LOAD);
  assign in_acc   = in_valid && !in_stall;
  assign cnt_inc  = cnt_r + 1'b1;
  assign set_end  = in_data.final_item || (cnt_inc == esa_pkg::CW'(esa_pkg::CAPACITY));

  // Shared comparator: held element against the one just read
  assign swap   = (cur_r > rdata);
  assign b_last = ({1'b0, b_r} == (n_r - 1'b1));
  assign a_last = (({1'b0, a_r} + esa_pkg::CW'(2)) == n_r);
  assign k_last = ({1'b0, k_r} == (n_r - 1'b1));

  // Next-state and store access
  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    n_nxt      = n_r;
    a_nxt      = a_r;
    b_nxt      = b_r;
    k_nxt      = k_r;
    cur_nxt    = cur_r;
    req.we     = 1'b0;
    req.waddr  = a_r;
    req.wdata  = cur_r;
    req.raddr  = a_r;
    emit.load  = 1'b0;
    emit.last  = 1'b0;
    case (state_r)
      esa_pkg::S_LOAD: begin
        if (in_acc) begin
          req.we    = 1'b1;
          req.waddr = cnt_r[esa_pkg::AW-1:0];
          req.wdata = in_data.value;
          if (set_end) begin
            n_nxt   = cnt_inc;
            cnt_nxt = '0;
            a_nxt   = '0;
            k_nxt   = '0;
            state_nxt = (cnt_inc == esa_pkg::CW'(1)) ? esa_pkg::S_ERD : esa_pkg::S_RDA;
          end else begin
            cnt_nxt = cnt_inc;
          end
        end
      end
      esa_pkg::S_RDA: begin
        req.raddr = a_r;
        b_nxt     = a_r + 1'b1;
        state_nxt = esa_pkg::S_RDB;
      end
      esa_pkg::S_RDB: begin
        req.raddr = b_r;
        cur_nxt   = rdata;
        state_nxt = esa_pkg::S_CMP;
      end
      esa_pkg::S_CMP: begin
        // rdata holds element b; the read of b+1 is already under way
        req.raddr = b_r + 1'b1;
        if (swap) begin
          req.we    = 1'b1;
          req.waddr = b_r;
          req.wdata = cur_r;
          cur_nxt   = rdata;
        end
        if (b_last) begin
          state_nxt = esa_pkg::S_WRA;
        end else begin
          b_nxt = b_r + 1'b1;
        end
      end
      esa_pkg::S_WRA: begin
        // Position a now holds its final value
        req.we    = 1'b1;
        req.waddr = a_r;
        req.wdata = cur_r;
        if (a_last) begin
          k_nxt     = '0;
          state_nxt = esa_pkg::S_ERD;
        end else begin
          a_nxt     = a_r + 1'b1;
          state_nxt = esa_pkg::S_RDA;
        end
      end
      esa_pkg::S_ERD: begin
        // Issue read of the first element; data is back next cycle
        req.raddr = k_r;
        state_nxt = esa_pkg::S_EMT;
      end
      esa_pkg::S_EMT: begin
        // rdata holds element k; address held while the output is busy
        req.raddr = k_r;
        if (out_free) begin
          emit.load = 1'b1;
          emit.last = k_last;
          if (k_last) begin
            state_nxt = esa_pkg::S_LOAD;
          end else begin
            k_nxt     = k_r + 1'b1;
            req.raddr = k_r + 1'b1;
          end
        end
      end
      default: begin
        state_nxt = esa_pkg::S_LOAD;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= esa_pkg::S_LOAD;
      cnt_r   <= '0;
      n_r     <= '0;
      a_r     <= '0;
      b_r     <= '0;
      k_r     <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      n_r     <= n_nxt;
      a_r     <= a_nxt;
      b_r     <= b_nxt;
      k_r     <= k_nxt;
    end
  end

  // Held element of the current pass
  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
  end

  // Inner index always runs ahead of the outer one
  a_cmp_order: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == esa_pkg::S_CMP) |-> (b_r > a_r))
    else $error("compare index not beyond pass index");

  // Load count is idle outside the load phase
  a_cnt_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != esa_pkg::S_LOAD) |-> (cnt_r == '0))
    else $error("load count nonzero during sort or emit");

  // A set being sorted or emitted is never empty
  a_n_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != esa_pkg::S_LOAD) |-> (n_r != '0))
    else $error("empty set outside load phase");

  // After the last result the block returns to loading
  a_last_done: assert property (@(posedge clk) disable iff (!rst_n)
    (emit.load && emit.last) |=> (state_r == esa_pkg::S_LOAD))
    else $error("sequencer did not return to load after last result");

endmodule

/* verif/esa_checker.sv */
// Checker for the exchange sort block: predicts each sorted run and compares the results.
`timescale 1ns / 100ps

module exchange_sort_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  esa_pkg::in_item_t  in_data,
  input  logic               out_valid,
  input  logic               out_stall,
  input  esa_pkg::out_item_t out_data,
  output int                 mismatches,
  output int                 pending
);

  // Model copy of the set being loaded
  logic signed [esa_pkg::DW-1:0] set_values [esa_pkg::CAPACITY];
  int                            set_fill;
  esa_pkg::out_item_t            sorted_expect [$];

  // Exchange sort of the loaded set, then queue it in ascending order
  task automatic sort_loaded_set();
    logic signed [esa_pkg::DW-1:0] tmp;
    esa_pkg::out_item_t            res;
    for (int a = 0; a + 1 < set_fill; a++) begin
      for (int b = a + 1; b < set_fill; b++) begin
        if (set_values[a] > set_values[b]) begin
          tmp           = set_values[a];
          set_values[a] = set_values[b];
          set_values[b] = tmp;
        end
      end
    end
    for (int k = 0; k < set_fill; k++) begin
      res.sorted_value = set_values[k];
      res.end_of_run   = (k == set_fill - 1);
      sorted_expect.push_back(res);
    end
    set_fill = 0;
  endtask

  // Watch both channels at each edge
  always @(posedge clk) begin : watch
    esa_pkg::out_item_t got;
    esa_pkg::out_item_t want;
    if (!rst_n) begin
      set_fill   = 0;
      mismatches = 0;
      sorted_expect.delete();
    end else begin
      if (in_valid && !in_stall) begin
        set_values[set_fill] = in_data.value;
        set_fill++;
        if (in_data.final_item || set_fill == esa_pkg::CAPACITY) sort_loaded_set();
      end
      if (out_valid && !out_stall) begin
        got = out_data;
        if (sorted_expect.size() == 0) begin
          $error("unexpected result transaction: sorted_value %0d, end_of_run %0b",
                 got.sorted_value, got.end_of_run);
          mismatches++;
        end else begin
          want = sorted_expect.pop_front();
          if (got.sorted_value !== want.sorted_value) begin
            $error("sorted_value: expected %0d, got %0d", want.sorted_value, got.sorted_value);
            mismatches++;
          end
          if (got.end_of_run !== want.end_of_run) begin
            $error("end_of_run: expected %0b, got %0b", want.end_of_run, got.end_of_run);
            mismatches++;
          end
        end
      end
    end
    pending = sorted_expect.size();
  end

endmodule

/* verif/exchange_sort_small_array_tb.sv */
// Testbench top for the exchange sort block: stimulus, receiver stalls and verdict.
`timescale 1ns / 100ps

module exchange_sort_small_array_tb;

  localparam int RANDOM_ITEMS = 450;
  localparam int HOLD_CYCLES  = 300;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int SETTLE       = 100;

  logic               clk       = 1'b0;
  logic               rst_n     = 1'b0;
  logic               in_valid  = 1'b0;
  esa_pkg::in_item_t  in_data   = '0;
  logic               in_stall;
  logic               out_valid;
  logic               out_stall = 1'b0;
  esa_pkg::out_item_t out_data;

  int mismatches;
  int pending_results;
  int cycles    = 0;
  bit calm      = 1'b0;
  bit hold_req  = 1'b0;

  exchange_sort_small_array dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_data   (in_data),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  exchange_sort_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .mismatches (mismatches),
    .pending    (pending_results)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Present one input transaction and wait until it is taken
  task automatic offer(input logic signed [esa_pkg::DW-1:0] v, input logic last);
    in_valid <= 1'b1;
    in_data  <= '{value: v, final_item: last};
    do @(posedge clk); while (in_stall);
  endtask

  // Random sender gap between transactions
  task automatic maybe_pause();
    if (!calm && $urandom_range(0, 99) < 18) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 2)) @(posedge clk);
    end
  endtask

  // Stop sending and wait until every queued result has come out
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results != 0);
  endtask

  // Mix of extremes, small values (ties) and full-range values
  function automatic logic signed [esa_pkg::DW-1:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return 16'sh8000;
      1:       return 16'sh7fff;
      2, 3:    return esa_pkg::DW'(int'($urandom_range(0, 7)) - 4);
      default: return esa_pkg::DW'($urandom());
    endcase
  endfunction

  // Receiver: random stalls, one long hold-off on request
  initial begin : result_sink
    int held = 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        held++;
        if (held == HOLD_CYCLES) hold_req = 1'b0;
      end else begin
        out_stall <= !calm && ($urandom_range(0, 99) < 22);
      end
    end
  end

  // Run limit
  initial begin : watchdog
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin : stimulus
    int   sent      = 0;
    int   set_size;
    bit   hold_done = 1'b0;
    bit   drained   = 1'b0;
    logic fin;
    logic signed [esa_pkg::DW-1:0] falling [8] = '{16'sh7fff, 16'sh0001, 16'sh0000,
                                                   16'shffff, 16'sh0001, 16'sh8000,
                                                   16'sh8000, 16'sh1234};
    logic signed [esa_pkg::DW-1:0] rising  [8] = '{16'sh8000, 16'shc000, 16'shfffe,
                                                   16'sh0000, 16'sh0000, 16'sh00ff,
                                                   16'sh5555, 16'sh7fff};

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: single-element sets at both extremes
    offer(16'sh8000, 1'b1);
    maybe_pause();
    offer(16'sh7fff, 1'b1);
    maybe_pause();
    // Full set ended by capacity alone, out of order with ties
    foreach (falling[i]) begin
      offer(falling[i], 1'b0);
      maybe_pause();
    end
    // Already sorted full set, flagged on the last element
    foreach (rising[i]) begin
      offer(rising[i], i == 7);
      maybe_pause();
    end
    // All-equal set and a two-element set in reverse order
    repeat (3) offer(-16'sd5, 1'b0);
    offer(-16'sd5, 1'b1);
    offer(16'sh0001, 1'b0);
    offer(16'sh8000, 1'b1);
    drain();

    // Random: mostly whole sets, some loose transactions with random flags
    while (sent < RANDOM_ITEMS) begin
      calm = (sent >= 150 && sent < 230);
      if (!hold_done && sent >= 300) begin
        hold_req  = 1'b1;
        hold_done = 1'b1;
      end
      if (!drained && sent >= 380) begin
        drain();
        drained = 1'b1;
      end
      if ($urandom_range(0, 9) < 7) begin
        set_size = $urandom_range(1, esa_pkg::CAPACITY);
        for (int i = 0; i < set_size; i++) begin
          fin = (i == set_size - 1) &&
                (set_size < esa_pkg::CAPACITY || $urandom_range(0, 1) == 1);
          offer(pick_value(), fin);
          maybe_pause();
          sent++;
        end
      end else begin
        offer(pick_value(), $urandom_range(0, 3) == 0);
        maybe_pause();
        sent++;
      end
    end

    // Close any open set, then let everything come out
    offer(pick_value(), 1'b1);
    drain();
    repeat (SETTLE) @(posedge clk);

    if (mismatches == 0 && pending_results == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

/* exchange_sort_small_array.f */
hdl/esa_pkg.sv
hdl/esa_store.sv
hdl/esa_seq.sv
hdl/exchange_sort_small_array.sv
verif/esa_checker.sv
verif/exchange_sort_small_array_tb.sv
